[hw/rtl/mrm_pkg.sv]
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types, operation codes and constants of the memory region map.
// ----------------------------------------------------------------------------
package mrm_pkg;

   // default table sizes
   localparam int REGION_SLOTS_DEF = 128;
   localparam int HOLE_SLOTS_DEF   = 64;
   localparam int NODE_LIMIT_DEF   = 8;

   // operation codes
   localparam logic [1:0] OP_ADD_REGION = 2'd0;
   localparam logic [1:0] OP_ADD_HOLE   = 2'd1;
   localparam logic [1:0] OP_LOOKUP     = 2'd2;
   localparam logic [1:0] OP_MARK       = 2'd3;

   // region kinds
   localparam logic [2:0] KIND_USABLE   = 3'd0;
   localparam logic [2:0] KIND_RESERVED = 3'd1;
   localparam logic [2:0] KIND_ACPI_REC = 3'd2;
   localparam logic [2:0] KIND_ACPI_NVS = 3'd3;
   localparam logic [2:0] KIND_UNKNOWN  = 3'd6;

   // running total slots
   localparam logic [2:0] TOT_ALL      = 3'd0;
   localparam logic [2:0] TOT_USABLE   = 3'd1;
   localparam logic [2:0] TOT_RESERVED = 3'd2;
   localparam logic [2:0] TOT_ACPI     = 3'd3;
   localparam logic [2:0] TOT_HOLE     = 3'd4;
   localparam logic [2:0] TOT_HIGH     = 3'd5;
   localparam int         TOT_COUNT    = 6;

   localparam logic [63:0] FOUR_GIB = 64'h0000_0001_0000_0000;

   typedef struct packed {
      logic [63:0] base;
      logic [63:0] size;
      logic [2:0]  kind;
      logic [2:0]  node;
   } region_entry_type;

   typedef struct packed {
      logic [63:0] base;
      logic [63:0] size;
   } hole_entry_type;

   // request to the shared range compare unit
   typedef struct packed {
      logic        exact;
      logic [63:0] addr;
      logic [63:0] len;
      logic [63:0] base;
      logic [63:0] size;
   } match_req_type;

endpackage

[hw/rtl/mrm_if.sv]
// ----------------------------------------------------------------------------
// mrm_if
// Request and response channels of the memory region map.
// ----------------------------------------------------------------------------
interface mrm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [63:0] address;
   logic [63:0] length;
   logic [2:0]  kind;
   logic [2:0]  node_in;

   modport source (output valid, operation, address, length, kind, node_in,
                   input ready);
   modport sink   (input valid, operation, address, length, kind, node_in,
                   output ready);
endinterface

interface mrm_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        hit;
   logic [2:0]  found_kind;
   logic [2:0]  found_node;
   logic        found_hotplug;
   logic        in_hole;
   logic [63:0] total_bytes;
   logic [63:0] usable_bytes;
   logic [63:0] reserved_bytes;
   logic [63:0] acpi_bytes;
   logic [63:0] hole_bytes;
   logic [63:0] high_bytes;

   modport source (output valid, accepted, hit, found_kind, found_node,
                   found_hotplug, in_hole, total_bytes, usable_bytes,
                   reserved_bytes, acpi_bytes, hole_bytes, high_bytes,
                   input ready);
   modport sink   (input valid, accepted, hit, found_kind, found_node,
                   found_hotplug, in_hole, total_bytes, usable_bytes,
                   reserved_bytes, acpi_bytes, hole_bytes, high_bytes,
                   output ready);
endinterface

[hw/rtl/mrm_match.sv]
// ----------------------------------------------------------------------------
// mrm_match
// Shared range compare: range cover test or exact base and length match.
// ----------------------------------------------------------------------------
module mrm_match (
   input  mrm_pkg::match_req_type req,
   output logic                   match
);
   logic [64:0] diff;
   logic        covered;

   // addr in [base, base+size) without wrap at the end
   assign diff    = {1'b0, req.addr} - {1'b0, req.base};
   assign covered = !diff[64] && (diff[63:0] < req.size);

   assign match = req.exact ? ((req.base == req.addr) && (req.size == req.len)) : covered;
endmodule

[hw/rtl/mrm_region_mem.sv]
// ----------------------------------------------------------------------------
// mrm_region_mem
// Region table storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mrm_region_mem #(
   parameter int SLOTS = mrm_pkg::REGION_SLOTS_DEF,
   parameter int IDX_W = 7
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_idx,
   input  mrm_pkg::region_entry_type wr_entry,
   input  logic                      hp_set,
   input  logic [IDX_W-1:0]          hp_idx,
   input  logic [IDX_W-1:0]          rd_idx,
   output mrm_pkg::region_entry_type rd_entry,
   output logic                      rd_hotplug
);
   mrm_pkg::region_entry_type entry_mem [SLOTS];
   logic                      hp_mem [SLOTS];
   logic [IDX_W-1:0]          hp_wr_idx;

   assign hp_wr_idx = wr_en ? wr_idx : hp_idx;

   // entry fields
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_idx] <= wr_entry;
      end
      rd_entry <= entry_mem[rd_idx];
   end

   // hotplug marks: cleared on add, set by a mark
   always_ff @(posedge clock) begin
      if (wr_en || hp_set) begin
         hp_mem[hp_wr_idx] <= !wr_en;
      end
      rd_hotplug <= hp_mem[rd_idx];
   end
endmodule

[hw/rtl/mrm_hole_mem.sv]
// ----------------------------------------------------------------------------
// mrm_hole_mem
// Hole table storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mrm_hole_mem #(
   parameter int SLOTS = mrm_pkg::HOLE_SLOTS_DEF,
   parameter int IDX_W = 6
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_idx,
   input  mrm_pkg::hole_entry_type wr_entry,
   input  logic [IDX_W-1:0]        rd_idx,
   output mrm_pkg::hole_entry_type rd_entry
);
   mrm_pkg::hole_entry_type entry_mem [SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_idx] <= wr_entry;
      end
      rd_entry <= entry_mem[rd_idx];
   end
endmodule

[hw/rtl/memory_region_map.sv]
// ----------------------------------------------------------------------------
// memory_region_map
// Table of memory regions and holes with running byte totals, range lookup
// and hotplug marking.
// ----------------------------------------------------------------------------
//   channel   dir   handshake        payload
//   req_chan  in    valid / ready    operation, address, length, kind, node_in
//   rsp_chan  out   valid / ready    flags, found fields, six byte totals
//
// One item at a time. Add region passes through the add, sum and response
// states, add hole through add and response. Lookup walks the region table then
// the hole table through one shared compare unit, one entry a cycle, with a
// registered table read ahead of each compare. Mark hotplug walks the region table only.
// Reset clears counts, totals and control; tables need no clearing.
// The response holds until taken; no new item is taken meanwhile.
// ----------------------------------------------------------------------------
module memory_region_map #(
   parameter int REGION_SLOTS = mrm_pkg::REGION_SLOTS_DEF,
   parameter int HOLE_SLOTS   = mrm_pkg::HOLE_SLOTS_DEF,
   parameter int NODE_LIMIT   = mrm_pkg::NODE_LIMIT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mrm_req_if.sink   req_chan,
   mrm_rsp_if.source rsp_chan
);
   localparam int RIDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
   localparam int HIDX_W = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
   localparam int RCNT_W = $clog2(REGION_SLOTS + 1);
   localparam int HCNT_W = $clog2(HOLE_SLOTS + 1);
   localparam int SCAN_W = (RCNT_W > HCNT_W) ? RCNT_W : HCNT_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_ADD   = 6'b000010,
      S_SUM   = 6'b000100,
      S_RSCAN = 6'b001000,
      S_HSCAN = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [63:0]        addr_ff, addr_in;
   logic [63:0]        len_ff, len_in;
   logic [2:0]         kind_ff, kind_in;
   logic [2:0]         node_ff, node_in;
   logic [RCNT_W-1:0]  rcnt_ff, rcnt_in;
   logic [HCNT_W-1:0]  hcnt_ff, hcnt_in;
   logic [SCAN_W-1:0]  idx_ff, idx_in;
   logic               issue_ff, issue_in;
   logic [RIDX_W-1:0]  issue_idx_ff, issue_idx_in;
   logic [63:0]        high_ff, high_in;
   logic [63:0]        tot_ff [mrm_pkg::TOT_COUNT];
   logic [63:0]        tot_in [mrm_pkg::TOT_COUNT];
   logic               acc_ff, acc_in;
   logic               hit_ff, hit_in;
   logic [2:0]         fkind_ff, fkind_in;
   logic [2:0]         fnode_ff, fnode_in;
   logic               fhot_ff, fhot_in;
   logic               inhole_ff, inhole_in;

   logic                      r_wr_en, hp_set, h_wr_en;
   mrm_pkg::region_entry_type r_wr_entry, r_rd_entry;
   mrm_pkg::hole_entry_type   h_wr_entry, h_rd_entry;
   logic                      r_rd_hotplug;
   mrm_pkg::match_req_type    cmp_req;
   logic                      cmp_match;
   logic [63:0]               gap;

   // storage and shared compare unit
   mrm_region_mem #(.SLOTS(REGION_SLOTS), .IDX_W(RIDX_W)) u_region (
      .clock     (clock),
      .wr_en     (r_wr_en),
      .wr_idx    (rcnt_ff[RIDX_W-1:0]),
      .wr_entry  (r_wr_entry),
      .hp_set    (hp_set),
      .hp_idx    (issue_idx_ff),
      .rd_idx    (idx_ff[RIDX_W-1:0]),
      .rd_entry  (r_rd_entry),
      .rd_hotplug(r_rd_hotplug)
   );

   mrm_hole_mem #(.SLOTS(HOLE_SLOTS), .IDX_W(HIDX_W)) u_hole (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_idx  (hcnt_ff[HIDX_W-1:0]),
      .wr_entry(h_wr_entry),
      .rd_idx  (idx_ff[HIDX_W-1:0]),
      .rd_entry(h_rd_entry)
   );

   mrm_match u_match (
      .req  (cmp_req),
      .match(cmp_match)
   );

   // write data and compare operands
   always_comb begin
      r_wr_entry.base = addr_ff;
      r_wr_entry.size = len_ff;
      r_wr_entry.kind = kind_ff;
      r_wr_entry.node = (32'(node_ff) < NODE_LIMIT) ? node_ff : 3'd0;
      h_wr_entry.base = addr_ff;
      h_wr_entry.size = len_ff;
      cmp_req.exact   = (state_ff == S_RSCAN) && (op_ff == mrm_pkg::OP_MARK);
      cmp_req.addr    = addr_ff;
      cmp_req.len     = len_ff;
      cmp_req.base    = (state_ff == S_HSCAN) ? h_rd_entry.base : r_rd_entry.base;
      cmp_req.size    = (state_ff == S_HSCAN) ? h_rd_entry.size : r_rd_entry.size;
      gap             = mrm_pkg::FOUR_GIB - addr_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      kind_in      = kind_ff;
      node_in      = node_ff;
      rcnt_in      = rcnt_ff;
      hcnt_in      = hcnt_ff;
      idx_in       = idx_ff;
      issue_in     = 1'b0;
      issue_idx_in = issue_idx_ff;
      high_in      = high_ff;
      tot_in       = tot_ff;
      acc_in       = acc_ff;
      hit_in       = hit_ff;
      fkind_in     = fkind_ff;
      fnode_in     = fnode_ff;
      fhot_in      = fhot_ff;
      inhole_in    = inhole_ff;
      r_wr_en      = 1'b0;
      h_wr_en      = 1'b0;
      hp_set       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in     = req_chan.operation;
               addr_in   = req_chan.address;
               len_in    = req_chan.length;
               kind_in   = req_chan.kind;
               node_in   = req_chan.node_in;
               idx_in    = '0;
               acc_in    = 1'b0;
               hit_in    = 1'b0;
               fkind_in  = mrm_pkg::KIND_UNKNOWN;
               fnode_in  = 3'd0;
               fhot_in   = 1'b0;
               inhole_in = 1'b0;
               if (req_chan.operation == mrm_pkg::OP_ADD_REGION ||
                   req_chan.operation == mrm_pkg::OP_ADD_HOLE) begin
                  state_in = S_ADD;
               end else begin
                  state_in = S_RSCAN;
               end
            end
         end
         S_ADD: begin
            state_in = S_RESP;
            if (op_ff == mrm_pkg::OP_ADD_REGION) begin
               if (rcnt_ff != RCNT_W'(REGION_SLOTS)) begin
                  r_wr_en  = 1'b1;
                  rcnt_in  = rcnt_ff + 1'b1;
                  acc_in   = 1'b1;
                  state_in = S_SUM;
                  // share at or above 4 GiB
                  if (addr_ff >= mrm_pkg::FOUR_GIB) begin
                     high_in = len_ff;
                  end else if (len_ff > gap) begin
                     high_in = len_ff - gap;
                  end else begin
                     high_in = '0;
                  end
               end
            end else if (hcnt_ff != HCNT_W'(HOLE_SLOTS)) begin
               h_wr_en  = 1'b1;
               hcnt_in  = hcnt_ff + 1'b1;
               acc_in   = 1'b1;
               tot_in[mrm_pkg::TOT_HOLE] = tot_ff[mrm_pkg::TOT_HOLE] + len_ff;
            end
         end
         S_SUM: begin
            tot_in[mrm_pkg::TOT_ALL]  = tot_ff[mrm_pkg::TOT_ALL] + len_ff;
            tot_in[mrm_pkg::TOT_HIGH] = tot_ff[mrm_pkg::TOT_HIGH] + high_ff;
            if (kind_ff == mrm_pkg::KIND_USABLE) begin
               tot_in[mrm_pkg::TOT_USABLE] = tot_ff[mrm_pkg::TOT_USABLE] + len_ff;
            end else if (kind_ff == mrm_pkg::KIND_RESERVED) begin
               tot_in[mrm_pkg::TOT_RESERVED] = tot_ff[mrm_pkg::TOT_RESERVED] + len_ff;
            end else if (kind_ff == mrm_pkg::KIND_ACPI_REC ||
                         kind_ff == mrm_pkg::KIND_ACPI_NVS) begin
               tot_in[mrm_pkg::TOT_ACPI] = tot_ff[mrm_pkg::TOT_ACPI] + len_ff;
            end
            state_in = S_RESP;
         end
         S_RSCAN: begin
            if (issue_ff && cmp_match) begin
               // first matching region
               hit_in   = 1'b1;
               fkind_in = r_rd_entry.kind;
               fnode_in = r_rd_entry.node;
               idx_in   = '0;
               if (op_ff == mrm_pkg::OP_MARK) begin
                  hp_set   = 1'b1;
                  fhot_in  = 1'b1;
                  state_in = S_RESP;
               end else begin
                  fhot_in  = r_rd_hotplug;
                  state_in = S_HSCAN;
               end
            end else if (idx_ff == SCAN_W'(rcnt_ff)) begin
               if (!issue_ff) begin
                  idx_in   = '0;
                  state_in = (op_ff == mrm_pkg::OP_MARK) ? S_RESP : S_HSCAN;
               end
            end else begin
               issue_in     = 1'b1;
               issue_idx_in = idx_ff[RIDX_W-1:0];
               idx_in       = idx_ff + 1'b1;
            end
         end
         S_HSCAN: begin
            if (issue_ff && cmp_match) begin
               inhole_in = 1'b1;
               state_in  = S_RESP;
            end else if (idx_ff == SCAN_W'(hcnt_ff)) begin
               if (!issue_ff) begin
                  state_in = S_RESP;
               end
            end else begin
               issue_in = 1'b1;
               idx_in   = idx_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rcnt_ff  <= '0;
         hcnt_ff  <= '0;
         issue_ff <= 1'b0;
         for (int t = 0; t < mrm_pkg::TOT_COUNT; t++) begin
            tot_ff[t] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rcnt_ff  <= rcnt_in;
         hcnt_ff  <= hcnt_in;
         issue_ff <= issue_in;
         tot_ff   <= tot_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      len_ff       <= len_in;
      kind_ff      <= kind_in;
      node_ff      <= node_in;
      idx_ff       <= idx_in;
      issue_idx_ff <= issue_idx_in;
      high_ff      <= high_in;
      acc_ff       <= acc_in;
      hit_ff       <= hit_in;
      fkind_ff     <= fkind_in;
      fnode_ff     <= fnode_in;
      fhot_ff      <= fhot_in;
      inhole_ff    <= inhole_in;
   end

   // channel outputs
   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = (state_ff == S_RESP);
   assign rsp_chan.accepted      = acc_ff;
   assign rsp_chan.hit           = hit_ff;
   assign rsp_chan.found_kind    = fkind_ff;
   assign rsp_chan.found_node    = fnode_ff;
   assign rsp_chan.found_hotplug = fhot_ff;
   assign rsp_chan.in_hole       = inhole_ff;
   assign rsp_chan.total_bytes    = tot_ff[mrm_pkg::TOT_ALL];
   assign rsp_chan.usable_bytes   = tot_ff[mrm_pkg::TOT_USABLE];
   assign rsp_chan.reserved_bytes = tot_ff[mrm_pkg::TOT_RESERVED];
   assign rsp_chan.acpi_bytes     = tot_ff[mrm_pkg::TOT_ACPI];
   assign rsp_chan.hole_bytes     = tot_ff[mrm_pkg::TOT_HOLE];
   assign rsp_chan.high_bytes     = tot_ff[mrm_pkg::TOT_HIGH];

`ifndef SYNTHESIS
   a_lookup_scans: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.operation == mrm_pkg::OP_LOOKUP)
      |=> (state_ff == S_RSCAN))
      else $error("lookup did not start region scan");

   a_region_count: assert property (@(posedge clock) disable iff (reset)
      (32'(rcnt_ff) <= REGION_SLOTS))
      else $error("region count beyond table size");

   a_hole_count: assert property (@(posedge clock) disable iff (reset)
      (32'(hcnt_ff) <= HOLE_SLOTS))
      else $error("hole count beyond table size");

   a_totals_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SUM) |=> $stable(tot_ff[mrm_pkg::TOT_ALL]))
      else $error("total bytes changed outside summing");
`endif
endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the memory region map: a local region and hole
// table predicts each response; directed cases cover the table limits, 4 GiB
// crossing, zero lengths and hotplug marks, interleaved with random items.
// ----------------------------------------------------------------------------
module testbench;

   localparam int REGIONS = mrm_pkg::REGION_SLOTS_DEF;
   localparam int HOLES   = mrm_pkg::HOLE_SLOTS_DEF;

   typedef struct packed {
      logic        accepted;
      logic        hit;
      logic [2:0]  found_kind;
      logic [2:0]  found_node;
      logic        found_hotplug;
      logic        in_hole;
      logic [63:0] total_bytes;
      logic [63:0] usable_bytes;
      logic [63:0] reserved_bytes;
      logic [63:0] acpi_bytes;
      logic [63:0] hole_bytes;
      logic [63:0] high_bytes;
   } map_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count = 0;
   bit   rsp_stall_on = 1'b1;
   bit   req_gap_on = 1'b1;

   mrm_req_if req_chan ();
   mrm_rsp_if rsp_chan ();

   memory_region_map dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #2 clock = ~clock;

   // predictor state
   logic [63:0] tbl_base [REGIONS];
   logic [63:0] tbl_size [REGIONS];
   logic [2:0]  tbl_kind [REGIONS];
   logic [2:0]  tbl_node [REGIONS];
   logic        tbl_hot  [REGIONS];
   int          tbl_count;
   logic [63:0] gap_base [HOLES];
   logic [63:0] gap_size [HOLES];
   int          gap_count;
   logic [63:0] sums [mrm_pkg::TOT_COUNT];
   map_rsp_type expected_rsps [$];

   function automatic bit covers(logic [63:0] base, logic [63:0] size, logic [63:0] a);
      return a >= base && (a - base) < size;
   endfunction

   // compute the response of one item and update the table copy
   function automatic map_rsp_type predict_map(logic [1:0] op, logic [63:0] a,
                                               logic [63:0] len, logic [2:0] k,
                                               logic [2:0] nd);
      map_rsp_type r;
      logic [63:0] gap;
      r = '0;
      r.found_kind = mrm_pkg::KIND_UNKNOWN;
      gap = mrm_pkg::FOUR_GIB - a;
      case (op)
         mrm_pkg::OP_ADD_REGION: begin
            if (tbl_count < REGIONS) begin
               tbl_base[tbl_count] = a;
               tbl_size[tbl_count] = len;
               tbl_kind[tbl_count] = k;
               tbl_node[tbl_count] = nd;
               tbl_hot[tbl_count] = 1'b0;
               tbl_count++;
               r.accepted = 1'b1;
               sums[mrm_pkg::TOT_ALL] += len;
               if (k == mrm_pkg::KIND_USABLE)
                  sums[mrm_pkg::TOT_USABLE] += len;
               else if (k == mrm_pkg::KIND_RESERVED)
                  sums[mrm_pkg::TOT_RESERVED] += len;
               else if (k == mrm_pkg::KIND_ACPI_REC || k == mrm_pkg::KIND_ACPI_NVS)
                  sums[mrm_pkg::TOT_ACPI] += len;
               if (a >= mrm_pkg::FOUR_GIB) sums[mrm_pkg::TOT_HIGH] += len;
               else if (len > gap) sums[mrm_pkg::TOT_HIGH] += len - gap;
            end
         end
         mrm_pkg::OP_ADD_HOLE: begin
            if (gap_count < HOLES) begin
               gap_base[gap_count] = a;
               gap_size[gap_count] = len;
               gap_count++;
               r.accepted = 1'b1;
               sums[mrm_pkg::TOT_HOLE] += len;
            end
         end
         mrm_pkg::OP_LOOKUP: begin
            for (int i = 0; i < tbl_count; i++)
               if (covers(tbl_base[i], tbl_size[i], a)) begin
                  r.hit = 1'b1;
                  r.found_kind = tbl_kind[i];
                  r.found_node = tbl_node[i];
                  r.found_hotplug = tbl_hot[i];
                  break;
               end
            for (int i = 0; i < gap_count; i++)
               if (covers(gap_base[i], gap_size[i], a)) begin
                  r.in_hole = 1'b1;
                  break;
               end
         end
         default: begin
            for (int i = 0; i < tbl_count; i++)
               if (tbl_base[i] == a && tbl_size[i] == len) begin
                  tbl_hot[i] = 1'b1;
                  r.hit = 1'b1;
                  r.found_kind = tbl_kind[i];
                  r.found_node = tbl_node[i];
                  r.found_hotplug = 1'b1;
                  break;
               end
         end
      endcase
      r.total_bytes = sums[mrm_pkg::TOT_ALL];
      r.usable_bytes = sums[mrm_pkg::TOT_USABLE];
      r.reserved_bytes = sums[mrm_pkg::TOT_RESERVED];
      r.acpi_bytes = sums[mrm_pkg::TOT_ACPI];
      r.hole_bytes = sums[mrm_pkg::TOT_HOLE];
      r.high_bytes = sums[mrm_pkg::TOT_HIGH];
      return r;
   endfunction

   // send one item, with an optional random gap before it
   task automatic send_item(logic [1:0] op, logic [63:0] a, logic [63:0] len,
                            logic [2:0] k, logic [2:0] nd);
      // valid was dropped at the previous falling edge
      @(negedge clock);
      if (req_gap_on && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 11)) @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.operation <= op;
      req_chan.address <= a;
      req_chan.length <= len;
      req_chan.kind <= k;
      req_chan.node_in <= nd;
      do @(posedge clock); while (!req_chan.ready);
      expected_rsps.push_back(predict_map(op, a, len, k, nd));
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // random address near an existing entry so lookups often hit
   function automatic logic [63:0] near_addr();
      int i;
      if (tbl_count == 0 || $urandom_range(0, 4) == 0) return rand64();
      i = $urandom_range(0, tbl_count - 1);
      case ($urandom_range(0, 3))
         0: return tbl_base[i];
         1: return tbl_base[i] + tbl_size[i] - 1;
         2: return tbl_base[i] + tbl_size[i];
         default: return tbl_base[i] + ($urandom() % (tbl_size[i] | 64'd1));
      endcase
   endfunction

   // response checker with random stalls
   always @(posedge clock) begin
      map_rsp_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_rsps.size() == 0) begin
            $error("response with no item outstanding");
            error_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_chan.accepted !== e.accepted) begin
               $error("accepted exp %0h got %0h", e.accepted, rsp_chan.accepted);
               error_count++;
            end
            if (rsp_chan.hit !== e.hit) begin
               $error("hit exp %0h got %0h", e.hit, rsp_chan.hit); error_count++;
            end
            if (rsp_chan.found_kind !== e.found_kind) begin
               $error("found_kind exp %0h got %0h", e.found_kind, rsp_chan.found_kind);
               error_count++;
            end
            if (rsp_chan.found_node !== e.found_node) begin
               $error("found_node exp %0h got %0h", e.found_node, rsp_chan.found_node);
               error_count++;
            end
            if (rsp_chan.found_hotplug !== e.found_hotplug) begin
               $error("found_hotplug exp %0h got %0h", e.found_hotplug,
                      rsp_chan.found_hotplug);
               error_count++;
            end
            if (rsp_chan.in_hole !== e.in_hole) begin
               $error("in_hole exp %0h got %0h", e.in_hole, rsp_chan.in_hole);
               error_count++;
            end
            if (rsp_chan.total_bytes !== e.total_bytes) begin
               $error("total_bytes exp %0h got %0h", e.total_bytes, rsp_chan.total_bytes);
               error_count++;
            end
            if (rsp_chan.usable_bytes !== e.usable_bytes) begin
               $error("usable_bytes exp %0h got %0h", e.usable_bytes,
                      rsp_chan.usable_bytes);
               error_count++;
            end
            if (rsp_chan.reserved_bytes !== e.reserved_bytes) begin
               $error("reserved_bytes exp %0h got %0h", e.reserved_bytes,
                      rsp_chan.reserved_bytes);
               error_count++;
            end
            if (rsp_chan.acpi_bytes !== e.acpi_bytes) begin
               $error("acpi_bytes exp %0h got %0h", e.acpi_bytes, rsp_chan.acpi_bytes);
               error_count++;
            end
            if (rsp_chan.hole_bytes !== e.hole_bytes) begin
               $error("hole_bytes exp %0h got %0h", e.hole_bytes, rsp_chan.hole_bytes);
               error_count++;
            end
            if (rsp_chan.high_bytes !== e.high_bytes) begin
               $error("high_bytes exp %0h got %0h", e.high_bytes, rsp_chan.high_bytes);
               error_count++;
            end
         end
      end
   end

   // ready pattern: bursts of stall, changed at the falling edge
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_on && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic test_edges();
      // empty-table lookup and mark
      send_item(mrm_pkg::OP_LOOKUP, 64'd0, 64'd0, 3'd0, 3'd0);
      send_item(mrm_pkg::OP_MARK, 64'd0, 64'd0, 3'd0, 3'd0);
      // one region of each kind, including the undefined kinds
      for (int k = 0; k < 8; k++)
         send_item(mrm_pkg::OP_ADD_REGION, 64'h1000 * (k + 1), 64'h800, 3'(k), 3'(7 - k));
      // crossing 4 GiB, fully high, top of space, zero length
      send_item(mrm_pkg::OP_ADD_REGION, mrm_pkg::FOUR_GIB - 64'h100, 64'h300,
                mrm_pkg::KIND_USABLE, 3'd1);
      send_item(mrm_pkg::OP_ADD_REGION, '1, '1, mrm_pkg::KIND_RESERVED, 3'd7);
      send_item(mrm_pkg::OP_ADD_REGION, 64'h9000, 64'd0, mrm_pkg::KIND_USABLE, 3'd2);
      send_item(mrm_pkg::OP_ADD_HOLE, 64'h1400, 64'h2000, 3'd0, 3'd0);
      send_item(mrm_pkg::OP_ADD_HOLE, '1, '1, 3'd0, 3'd0);
      send_item(mrm_pkg::OP_LOOKUP, 64'h9000, 64'd0, 3'd0, 3'd0);
      send_item(mrm_pkg::OP_LOOKUP, 64'h17FF, 64'd0, 3'd0, 3'd0);
      send_item(mrm_pkg::OP_LOOKUP, '1, 64'd0, 3'd0, 3'd0);
      send_item(mrm_pkg::OP_MARK, 64'h9000, 64'd0, 3'd0, 3'd0);
      send_item(mrm_pkg::OP_MARK, 64'h2000, 64'h800, 3'd0, 3'd0);
      send_item(mrm_pkg::OP_LOOKUP, 64'h2400, 64'd0, 3'd0, 3'd0);
      send_item(mrm_pkg::OP_MARK, 64'h2000, 64'h801, 3'd0, 3'd0);
      wait_drained();
   endtask

   // fill both tables, then push adds past capacity
   task automatic test_full_tables();
      while (tbl_count < REGIONS)
         send_item(mrm_pkg::OP_ADD_REGION, rand64(), {32'd0, $urandom()},
                   3'($urandom_range(0, 7)), 3'($urandom()));
      while (gap_count < HOLES)
         send_item(mrm_pkg::OP_ADD_HOLE, rand64(), rand64(), 3'($urandom()),
                   3'($urandom()));
      repeat (2) begin
         send_item(mrm_pkg::OP_ADD_REGION, 64'h5, 64'h5, mrm_pkg::KIND_USABLE, 3'd0);
         send_item(mrm_pkg::OP_ADD_HOLE, 64'h5, 64'h5, 3'd0, 3'd0);
      end
      wait_drained();
   endtask

   // random adds, lookups and marks against the loaded tables
   task automatic test_random_queries(int n);
      logic [1:0] op;
      logic [63:0] a;
      int i;
      for (int j = 0; j < n; j++) begin
         op = 2'($urandom_range(0, 3));
         a = near_addr();
         if (op == mrm_pkg::OP_MARK && tbl_count > 0 && $urandom_range(0, 1)) begin
            i = $urandom_range(0, tbl_count - 1);
            send_item(op, tbl_base[i], tbl_size[i], 3'($urandom()), 3'($urandom()));
         end else begin
            send_item(op, a, $urandom_range(0, 1) ? rand64() : 64'($urandom()),
                      3'($urandom()), 3'($urandom()));
         end
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.operation = mrm_pkg::OP_LOOKUP;
      req_chan.address = '0;
      req_chan.length = '0;
      req_chan.kind = '0;
      req_chan.node_in = '0;
      tbl_count = 0;
      gap_count = 0;
      foreach (sums[i]) sums[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_edges();
      test_random_queries(400);
      wait_drained();
      test_full_tables();
      test_random_queries(1000);
      rsp_stall_on = 1'b0;
      req_gap_on = 1'b0;
      test_random_queries(200);
      wait_drained();
      repeat (300) @(negedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // run limit
   initial begin
      #20000000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule
